// File: hw/rtl/sdspi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_pkg
// shared types and constants of the spi-mode sd block transfer engine
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int unsigned BlockBytes = 512;
    localparam int unsigned WakeBytes  = 10;

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD8, PH_R7, PH_CMD55, PH_CMD41, PH_CMD58,
        PH_OCR, PH_CMD17, PH_TOKEN, PH_RDATA, PH_RCRC, PH_CMD24, PH_WTOKEN,
        PH_WDATA, PH_WCRC, PH_WRESP, PH_BUSY
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0, OP_INIT = 3'd1, OP_READ = 3'd2, OP_WRITE = 3'd3,
        OP_APPEND = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOT_READY = 3'd1, ST_NO_IDLE = 3'd2, ST_INIT_TIMEOUT = 3'd3,
        ST_CMD_REJECTED = 3'd4, ST_TOKEN_TIMEOUT = 3'd5, ST_DATA_REJECTED = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        REG_RING_START = 3'd0, REG_RING_TOTAL = 3'd1, REG_RESP_TRIES = 3'd2,
        REG_INIT_TRIES = 3'd3, REG_TOKEN_TRIES = 3'd4, REG_BUSY_TRIES = 3'd5
    } t_reg;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] block_address;
        logic [7:0]  card_byte;
        logic [7:0]  payload_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       exchange_request;
        logic       chip_select_active;
        logic       pause_ms;
        logic       payload_taken;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic [2:0] status;
        logic       card_ready;
    } t_rsp;

    // byte i of a six-byte command frame
    function automatic logic [7:0] cmd_byte(t_phase p, logic [2:0] i, logic [31:0] tgt);
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  crc;
        logic [7:0]  res;
        cmd = 6'd24; arg = tgt; crc = 8'h00;
        unique case (p)
            PH_CMD0:  begin cmd = 6'd0;  arg = 32'h0;          crc = 8'h94; end
            PH_CMD8:  begin cmd = 6'd8;  arg = 32'h000001AA;   crc = 8'h86; end
            PH_CMD55: begin cmd = 6'd55; arg = 32'h0;          end
            PH_CMD41: begin cmd = 6'd41; arg = 32'h40000000;   end
            PH_CMD58: begin cmd = 6'd58; arg = 32'h0;          end
            PH_CMD17: begin cmd = 6'd17; arg = tgt;            end
            default:  begin cmd = 6'd24; arg = tgt;            end
        endcase
        case (i)
            3'd0:    res = {2'b01, cmd};
            3'd1:    res = arg[31:24];
            3'd2:    res = arg[23:16];
            3'd3:    res = arg[15:8];
            3'd4:    res = arg[7:0];
            default: res = crc | 8'h01;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sdspi_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_stream_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface sdspi_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sd_spi_block_transfer_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_engine_core
// spi-mode sd card sequencer: init, block read, block write, ring append
// ----------------------------------------------------------------------------
// One input transaction is one finished spi byte exchange (or an operation
// start while idle) and gives exactly one result transaction naming the next
// byte to send. The sequencer step is combinational logic on the phase, counter
// and target registers, so a new transaction is taken every cycle unless the
// result register is full and the sink stalls; the result is registered, held
// while the sink stalls and replaced in the same cycle it is taken.
module sd_spi_block_transfer_engine_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    sdspi_stream_if.sink   s_in,
    sdspi_stream_if.source m_out
);
    logic [31:0] r_ring_start, r_ring_total;
    logic [7:0]  r_resp_tries;
    logic [15:0] r_init_tries, r_token_tries, r_busy_tries;

    sdspi_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_byte_count, n_byte_count, r_try_count, n_try_count;
    logic [31:0] r_target, n_target, r_ring_ptr, n_ring_ptr;
    logic        r_ready, n_ready, r_ring_mode, n_ring_mode;

    sdspi_pkg::t_rsp r_out, n_out;
    logic            r_out_valid;

    logic accept;
    assign s_in.ready  = !r_out_valid || m_out.ready;
    assign accept      = s_in.valid && s_in.ready;
    assign m_out.valid = r_out_valid;
    assign m_out.data  = r_out;

    // effective try limits: zero acts as one
    logic [7:0]  resp_lim;
    logic [15:0] init_lim, token_lim, busy_lim;
    assign resp_lim  = (r_resp_tries == '0) ? 8'd1 : r_resp_tries;
    assign init_lim  = (r_init_tries == '0) ? 16'd1 : r_init_tries;
    assign token_lim = (r_token_tries == '0) ? 16'd1 : r_token_tries;
    assign busy_lim  = (r_busy_tries == '0) ? 16'd1 : r_busy_tries;

    logic [32:0] ring_next, ring_end;
    assign ring_next = {1'b0, r_ring_ptr} + 33'd1;
    assign ring_end  = {1'b0, r_ring_start} + {1'b0, r_ring_total};

    logic [15:0] poll_idx;
    assign poll_idx = r_byte_count - 16'd6;

    always_comb begin
        logic [7:0] cb;
        logic [7:0] pay;
        cb  = s_in.data.card_byte;
        pay = s_in.data.payload_byte;
        n_phase = r_phase; n_byte_count = r_byte_count; n_try_count = r_try_count;
        n_target = r_target; n_ring_ptr = r_ring_ptr; n_ready = r_ready;
        n_ring_mode = r_ring_mode;
        n_out = '0;

        if (r_phase == sdspi_pkg::PH_IDLE) begin
            case (s_in.data.operation)
                sdspi_pkg::OP_INIT: begin
                    n_phase = sdspi_pkg::PH_WAKE; n_byte_count = 16'd1;
                    n_out.tx_byte = 8'hFF; n_out.exchange_request = 1'b1;
                end
                sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: begin
                    n_target = s_in.data.block_address; n_ring_mode = 1'b0;
                    n_phase = (s_in.data.operation == sdspi_pkg::OP_READ)
                            ? sdspi_pkg::PH_CMD17 : sdspi_pkg::PH_CMD24;
                    n_byte_count = 16'd1;
                    n_out.tx_byte = sdspi_pkg::cmd_byte(n_phase, 3'd0, n_target);
                    n_out.exchange_request = 1'b1; n_out.chip_select_active = 1'b1;
                end
                sdspi_pkg::OP_APPEND: begin
                    if (!r_ready) begin
                        n_ring_mode = 1'b0; n_out.done_res = 1'b1;
                        n_out.status = sdspi_pkg::ST_NOT_READY;
                    end else begin
                        n_target = r_ring_ptr; n_ring_mode = 1'b1;
                        n_phase = sdspi_pkg::PH_CMD24; n_byte_count = 16'd1;
                        n_out.tx_byte = sdspi_pkg::cmd_byte(sdspi_pkg::PH_CMD24, 3'd0,
                                                            r_ring_ptr);
                        n_out.exchange_request = 1'b1; n_out.chip_select_active = 1'b1;
                    end
                end
                default: ;
            endcase
        end else begin
            // default for any exchange that asks for another byte
            n_out.exchange_request = 1'b1; n_out.chip_select_active = 1'b1;
            n_out.tx_byte = 8'hFF;
            unique case (r_phase)
                sdspi_pkg::PH_WAKE: begin
                    if (r_byte_count < 16'(sdspi_pkg::WakeBytes)) begin
                        n_byte_count = r_byte_count + 16'd1;
                        n_out.chip_select_active = 1'b0;
                    end else begin
                        n_phase = sdspi_pkg::PH_CMD0; n_byte_count = 16'd1;
                        n_out.tx_byte = sdspi_pkg::cmd_byte(sdspi_pkg::PH_CMD0, 3'd0,
                                                            r_target);
                    end
                end
                sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD8, sdspi_pkg::PH_CMD55,
                sdspi_pkg::PH_CMD41, sdspi_pkg::PH_CMD58, sdspi_pkg::PH_CMD17,
                sdspi_pkg::PH_CMD24: begin
                    if (r_byte_count < 16'd6) begin
                        n_out.tx_byte = sdspi_pkg::cmd_byte(r_phase, r_byte_count[2:0],
                                                            r_target);
                        n_byte_count = r_byte_count + 16'd1;
                    end else if (r_byte_count == 16'd6) begin
                        n_byte_count = r_byte_count + 16'd1;
                    end else if (cb != 8'hFF || poll_idx >= {8'd0, resp_lim}) begin
                        // response byte handling
                        n_byte_count = 16'd1;
                        unique case (r_phase)
                            sdspi_pkg::PH_CMD0: begin
                                if (cb == 8'h01) begin
                                    n_phase = sdspi_pkg::PH_CMD8;
                                    n_out.tx_byte = sdspi_pkg::cmd_byte(
                                        sdspi_pkg::PH_CMD8, 3'd0, r_target);
                                end else begin
                                    n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                                    n_out = '0; n_out.done_res = 1'b1;
                                    n_out.status = sdspi_pkg::ST_NO_IDLE;
                                end
                            end
                            sdspi_pkg::PH_CMD8: n_phase = sdspi_pkg::PH_R7;
                            sdspi_pkg::PH_CMD55: begin
                                n_phase = sdspi_pkg::PH_CMD41;
                                n_out.tx_byte = sdspi_pkg::cmd_byte(
                                    sdspi_pkg::PH_CMD41, 3'd0, r_target);
                            end
                            sdspi_pkg::PH_CMD41: begin
                                if (cb == 8'h00) begin
                                    n_phase = sdspi_pkg::PH_CMD58;
                                    n_out.tx_byte = sdspi_pkg::cmd_byte(
                                        sdspi_pkg::PH_CMD58, 3'd0, r_target);
                                end else begin
                                    n_try_count = r_try_count + 16'd1;
                                    if (n_try_count >= init_lim) begin
                                        n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                                        n_out = '0; n_out.done_res = 1'b1;
                                        n_out.status = sdspi_pkg::ST_INIT_TIMEOUT;
                                    end else begin
                                        n_phase = sdspi_pkg::PH_CMD55;
                                        n_out.pause_ms = 1'b1;
                                        n_out.tx_byte = sdspi_pkg::cmd_byte(
                                            sdspi_pkg::PH_CMD55, 3'd0, r_target);
                                    end
                                end
                            end
                            sdspi_pkg::PH_CMD58: n_phase = sdspi_pkg::PH_OCR;
                            sdspi_pkg::PH_CMD17: begin
                                if (cb == 8'h00) begin
                                    n_phase = sdspi_pkg::PH_TOKEN; n_try_count = 16'd1;
                                end else begin
                                    n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                                    n_out = '0; n_out.done_res = 1'b1;
                                    n_out.status = sdspi_pkg::ST_CMD_REJECTED;
                                end
                            end
                            default: begin
                                if (cb == 8'h00) begin
                                    n_phase = sdspi_pkg::PH_WTOKEN; n_out.tx_byte = 8'hFE;
                                    n_byte_count = r_byte_count;
                                end else begin
                                    n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                                    n_out = '0; n_out.done_res = 1'b1;
                                    n_out.status = sdspi_pkg::ST_CMD_REJECTED;
                                end
                            end
                        endcase
                    end else begin
                        n_byte_count = r_byte_count + 16'd1;
                    end
                end
                sdspi_pkg::PH_R7, sdspi_pkg::PH_OCR: begin
                    if (r_byte_count < 16'd4) begin
                        n_byte_count = r_byte_count + 16'd1;
                    end else if (r_phase == sdspi_pkg::PH_R7) begin
                        n_try_count = '0; n_phase = sdspi_pkg::PH_CMD55;
                        n_byte_count = 16'd1;
                        n_out.tx_byte = sdspi_pkg::cmd_byte(sdspi_pkg::PH_CMD55, 3'd0,
                                                            r_target);
                    end else begin
                        n_ready = 1'b1; n_ring_ptr = r_ring_start;
                        n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                        n_out = '0; n_out.done_res = 1'b1;
                        n_out.status = sdspi_pkg::ST_OK;
                    end
                end
                sdspi_pkg::PH_TOKEN: begin
                    if (cb == 8'hFE) begin
                        n_phase = sdspi_pkg::PH_RDATA; n_byte_count = 16'd1;
                    end else if (r_try_count >= token_lim) begin
                        n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                        n_out = '0; n_out.done_res = 1'b1;
                        n_out.status = sdspi_pkg::ST_TOKEN_TIMEOUT;
                    end else begin
                        n_try_count = r_try_count + 16'd1;
                    end
                end
                sdspi_pkg::PH_RDATA: begin
                    n_out.read_byte = cb; n_out.read_valid = 1'b1;
                    if (r_byte_count < 16'(sdspi_pkg::BlockBytes)) begin
                        n_byte_count = r_byte_count + 16'd1;
                    end else begin
                        n_phase = sdspi_pkg::PH_RCRC; n_byte_count = 16'd1;
                    end
                end
                sdspi_pkg::PH_RCRC: begin
                    if (r_byte_count < 16'd2) begin
                        n_byte_count = r_byte_count + 16'd1;
                    end else begin
                        n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                        n_out = '0; n_out.done_res = 1'b1;
                        n_out.status = sdspi_pkg::ST_OK;
                    end
                end
                sdspi_pkg::PH_WTOKEN: begin
                    n_phase = sdspi_pkg::PH_WDATA; n_byte_count = 16'd1;
                    n_out.tx_byte = pay; n_out.payload_taken = 1'b1;
                end
                sdspi_pkg::PH_WDATA: begin
                    if (r_byte_count < 16'(sdspi_pkg::BlockBytes)) begin
                        n_byte_count = r_byte_count + 16'd1;
                        n_out.tx_byte = pay; n_out.payload_taken = 1'b1;
                    end else begin
                        n_phase = sdspi_pkg::PH_WCRC; n_byte_count = 16'd1;
                    end
                end
                sdspi_pkg::PH_WCRC: begin
                    if (r_byte_count < 16'd2) begin
                        n_byte_count = r_byte_count + 16'd1;
                    end else begin
                        n_phase = sdspi_pkg::PH_WRESP;
                    end
                end
                sdspi_pkg::PH_WRESP: begin
                    if ((cb & 8'h1F) != 8'h05) begin
                        n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                        n_out = '0; n_out.done_res = 1'b1;
                        n_out.status = sdspi_pkg::ST_DATA_REJECTED;
                    end else begin
                        n_phase = sdspi_pkg::PH_BUSY; n_try_count = 16'd1;
                    end
                end
                sdspi_pkg::PH_BUSY: begin
                    if (cb != 8'h00 || r_try_count >= busy_lim) begin
                        // busy timeout still ends ok
                        if (r_ring_mode) begin
                            n_ring_ptr = (ring_next >= ring_end) ? r_ring_start
                                                                 : ring_next[31:0];
                        end
                        n_phase = sdspi_pkg::PH_IDLE; n_ring_mode = 1'b0;
                        n_out = '0; n_out.done_res = 1'b1;
                        n_out.status = sdspi_pkg::ST_OK;
                    end else begin
                        n_try_count = r_try_count + 16'd1;
                    end
                end
                default: begin
                    n_phase = sdspi_pkg::PH_IDLE; n_out = '0;
                end
            endcase
        end
        n_out.card_ready = n_ready;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_start <= 32'd1000; r_ring_total <= 32'd8388608;
            r_resp_tries <= 8'd8; r_init_tries <= 16'd1000;
            r_token_tries <= 16'd1000; r_busy_tries <= 16'd50000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdspi_pkg::REG_RING_START:  r_ring_start  <= i_cfg_data;
                sdspi_pkg::REG_RING_TOTAL:  r_ring_total  <= i_cfg_data;
                sdspi_pkg::REG_RESP_TRIES:  r_resp_tries  <= i_cfg_data[7:0];
                sdspi_pkg::REG_INIT_TRIES:  r_init_tries  <= i_cfg_data[15:0];
                sdspi_pkg::REG_TOKEN_TRIES: r_token_tries <= i_cfg_data[15:0];
                sdspi_pkg::REG_BUSY_TRIES:  r_busy_tries  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdspi_pkg::PH_IDLE; r_byte_count <= '0; r_try_count <= '0;
            r_target <= '0; r_ring_ptr <= 32'd1000; r_ready <= 1'b0;
            r_ring_mode <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase; r_byte_count <= n_byte_count;
                r_try_count <= n_try_count; r_target <= n_target;
                r_ring_ptr <= n_ring_ptr; r_ready <= n_ready;
                r_ring_mode <= n_ring_mode;
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/sdspi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_checker
// port-level checks of the sd spi transfer engine
// ----------------------------------------------------------------------------
module sdspi_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              in_valid,
    input wire              in_ready,
    input wire              out_valid,
    input wire              out_ready,
    input sdspi_pkg::t_rsp  out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("transaction gave no result");
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.exchange_request |->
        out_data.tx_byte == 8'h00 && !out_data.pause_ms && !out_data.chip_select_active)
        else $error("unused exchange fields not zero");
    a_done_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.done_res |-> !out_data.exchange_request)
        else $error("done with exchange request");
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");
endmodule

bind sd_spi_block_transfer_engine_core sdspi_checker u_sdspi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_data(m_out.data)
);
`default_nettype wire

// File: verif/sd_spi_block_transfer_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_block_transfer_engine_core_test
// self-checking bench for the spi-mode sd sequencer: a directed table, then
// card-like random traffic under several register settings; every result
// transaction is checked field by field against the table or an in-bench model
// ----------------------------------------------------------------------------
module sd_spi_block_transfer_engine_core_test;

    localparam logic [2:0] OP_UNUSED = 3'd7;   // undefined opcode, ignored when idle
    localparam int RandomItems = 1750;
    localparam int Phases      = 5;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    sdspi_stream_if #(.T(sdspi_pkg::t_req)) in_ch ();
    sdspi_stream_if #(.T(sdspi_pkg::t_rsp)) out_ch ();

    sd_spi_block_transfer_engine_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_in        (in_ch.sink),
        .m_out       (out_ch.source)
    );

    // clock: 12 ns period
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // sequencer model: registers, state and the result being built
    // ------------------------------------------------------------------
    logic [31:0] ring_base, ring_len;
    logic [7:0]  resp_limit;
    logic [15:0] init_limit, token_limit, busy_limit;

    sdspi_pkg::t_phase seq_phase;
    logic [15:0]       byte_cnt, try_cnt;
    logic [31:0]       cur_block, ring_ptr;
    logic              card_up, appending;
    sdspi_pkg::t_rsp   step_out;

    sdspi_pkg::t_rsp   pending_rsp[$];    // results owed by the block, oldest first
    int                errors;
    int                rx_cycle;
    int                sent;              // random transactions offered so far
    bit                steady;            // both sides run with no idling

    function automatic int unsigned at_least_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // one byte of a six-byte command frame for the given command phase
    function automatic logic [7:0] frame_byte(sdspi_pkg::t_phase p, int idx);
        logic [5:0]  code;
        logic [31:0] arg;
        logic [7:0]  crc;
        code = 6'd24; arg = cur_block; crc = 8'h00;
        case (p)
            sdspi_pkg::PH_CMD0:  begin code = 6'd0;  arg = 32'h0;        crc = 8'h94; end
            sdspi_pkg::PH_CMD8:  begin code = 6'd8;  arg = 32'h000001AA; crc = 8'h86; end
            sdspi_pkg::PH_CMD55: begin code = 6'd55; arg = 32'h0;        end
            sdspi_pkg::PH_CMD41: begin code = 6'd41; arg = 32'h40000000; end
            sdspi_pkg::PH_CMD58: begin code = 6'd58; arg = 32'h0;        end
            sdspi_pkg::PH_CMD17: code = 6'd17;
            default:             code = 6'd24;
        endcase
        if (idx == 0) return {2'b01, code};
        if (idx >= 5) return crc | 8'h01;
        return arg[8*(4-idx) +: 8];
    endfunction

    function automatic void emit(logic [7:0] b);
        step_out.tx_byte = b;
        step_out.exchange_request = 1'b1;
        step_out.chip_select_active = 1'b1;
    endfunction

    function automatic void close_op(sdspi_pkg::t_status st);
        seq_phase = sdspi_pkg::PH_IDLE;
        appending = 1'b0;
        step_out.done_res = 1'b1;
        step_out.status = st;
    endfunction

    function automatic void begin_cmd(sdspi_pkg::t_phase p);
        seq_phase = p;
        byte_cnt = 16'd1;
        emit(frame_byte(p, 0));
    endfunction

    function automatic void append_done();
        logic [32:0] nxt;
        if (appending) begin
            nxt = {1'b0, ring_ptr} + 33'd1;
            // wrap is judged on the unwrapped 33-bit sum
            if (nxt >= {1'b0, ring_base} + {1'b0, ring_len}) ring_ptr = ring_base;
            else ring_ptr = nxt[31:0];
        end
        close_op(sdspi_pkg::ST_OK);
    endfunction

    function automatic void got_response(logic [7:0] r);
        case (seq_phase)
            sdspi_pkg::PH_CMD0: begin
                if (r == 8'h01) begin_cmd(sdspi_pkg::PH_CMD8);
                else close_op(sdspi_pkg::ST_NO_IDLE);
            end
            sdspi_pkg::PH_CMD8: begin
                seq_phase = sdspi_pkg::PH_R7; byte_cnt = 16'd1; emit(8'hFF);
            end
            sdspi_pkg::PH_CMD55: begin_cmd(sdspi_pkg::PH_CMD41);
            sdspi_pkg::PH_CMD41: begin
                if (r == 8'h00) begin_cmd(sdspi_pkg::PH_CMD58);
                else begin
                    try_cnt = try_cnt + 16'd1;
                    if (try_cnt >= at_least_one(init_limit))
                        close_op(sdspi_pkg::ST_INIT_TIMEOUT);
                    else begin
                        begin_cmd(sdspi_pkg::PH_CMD55);
                        step_out.pause_ms = 1'b1;
                    end
                end
            end
            sdspi_pkg::PH_CMD58: begin
                seq_phase = sdspi_pkg::PH_OCR; byte_cnt = 16'd1; emit(8'hFF);
            end
            sdspi_pkg::PH_CMD17: begin
                if (r == 8'h00) begin
                    seq_phase = sdspi_pkg::PH_TOKEN; try_cnt = 16'd1; emit(8'hFF);
                end else close_op(sdspi_pkg::ST_CMD_REJECTED);
            end
            default: begin
                if (r == 8'h00) begin
                    seq_phase = sdspi_pkg::PH_WTOKEN; emit(8'hFE);
                end else close_op(sdspi_pkg::ST_CMD_REJECTED);
            end
        endcase
    endfunction

    function automatic void exchange_done(logic [7:0] cb, logic [7:0] pay);
        case (seq_phase)
            sdspi_pkg::PH_WAKE: begin
                if (byte_cnt < sdspi_pkg::WakeBytes) begin
                    byte_cnt++;
                    emit(8'hFF);
                    step_out.chip_select_active = 1'b0;
                end else begin_cmd(sdspi_pkg::PH_CMD0);
            end
            sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD8, sdspi_pkg::PH_CMD55,
            sdspi_pkg::PH_CMD41, sdspi_pkg::PH_CMD58, sdspi_pkg::PH_CMD17,
            sdspi_pkg::PH_CMD24: begin
                if (byte_cnt < 6) begin
                    emit(frame_byte(seq_phase, byte_cnt));
                    byte_cnt++;
                end else if (byte_cnt == 6) begin
                    emit(8'hFF);
                    byte_cnt++;
                end else if (cb != 8'hFF ||
                             int'(byte_cnt) - 6 >= at_least_one(resp_limit)) begin
                    // an all-0xff poll ends by taking 0xff as the response
                    got_response(cb);
                end else begin
                    emit(8'hFF);
                    byte_cnt++;
                end
            end
            sdspi_pkg::PH_R7: begin
                if (byte_cnt < 4) begin byte_cnt++; emit(8'hFF); end
                else begin try_cnt = 16'd0; begin_cmd(sdspi_pkg::PH_CMD55); end
            end
            sdspi_pkg::PH_OCR: begin
                if (byte_cnt < 4) begin byte_cnt++; emit(8'hFF); end
                else begin
                    card_up = 1'b1;
                    ring_ptr = ring_base;
                    close_op(sdspi_pkg::ST_OK);
                end
            end
            sdspi_pkg::PH_TOKEN: begin
                if (cb == 8'hFE) begin
                    seq_phase = sdspi_pkg::PH_RDATA; byte_cnt = 16'd1; emit(8'hFF);
                end else if (try_cnt >= at_least_one(token_limit))
                    close_op(sdspi_pkg::ST_TOKEN_TIMEOUT);
                else begin try_cnt++; emit(8'hFF); end
            end
            sdspi_pkg::PH_RDATA: begin
                step_out.read_byte = cb;
                step_out.read_valid = 1'b1;
                if (byte_cnt < sdspi_pkg::BlockBytes) byte_cnt++;
                else begin seq_phase = sdspi_pkg::PH_RCRC; byte_cnt = 16'd1; end
                emit(8'hFF);
            end
            sdspi_pkg::PH_RCRC: begin
                if (byte_cnt < 2) begin byte_cnt++; emit(8'hFF); end
                else close_op(sdspi_pkg::ST_OK);
            end
            sdspi_pkg::PH_WTOKEN: begin
                seq_phase = sdspi_pkg::PH_WDATA; byte_cnt = 16'd1;
                emit(pay); step_out.payload_taken = 1'b1;
            end
            sdspi_pkg::PH_WDATA: begin
                if (byte_cnt < sdspi_pkg::BlockBytes) begin
                    byte_cnt++; emit(pay); step_out.payload_taken = 1'b1;
                end else begin
                    seq_phase = sdspi_pkg::PH_WCRC; byte_cnt = 16'd1; emit(8'hFF);
                end
            end
            sdspi_pkg::PH_WCRC: begin
                if (byte_cnt < 2) begin byte_cnt++; emit(8'hFF); end
                else begin seq_phase = sdspi_pkg::PH_WRESP; emit(8'hFF); end
            end
            sdspi_pkg::PH_WRESP: begin
                if ((cb & 8'h1F) != 8'h05) close_op(sdspi_pkg::ST_DATA_REJECTED);
                else begin
                    seq_phase = sdspi_pkg::PH_BUSY; try_cnt = 16'd1; emit(8'hFF);
                end
            end
            sdspi_pkg::PH_BUSY: begin
                // busy timeout still counts as a good write
                if (cb != 8'h00 || try_cnt >= at_least_one(busy_limit)) append_done();
                else begin try_cnt++; emit(8'hFF); end
            end
            default: seq_phase = sdspi_pkg::PH_IDLE;
        endcase
    endfunction

    // advance the model by one accepted transaction, return the result it owes
    function automatic sdspi_pkg::t_rsp sequencer_step(sdspi_pkg::t_req q);
        step_out = '0;
        if (seq_phase != sdspi_pkg::PH_IDLE) begin
            // a start while busy is just another finished exchange
            exchange_done(q.card_byte, q.payload_byte);
        end else begin
            case (q.operation)
                sdspi_pkg::OP_INIT: begin
                    seq_phase = sdspi_pkg::PH_WAKE; byte_cnt = 16'd1;
                    emit(8'hFF); step_out.chip_select_active = 1'b0;
                end
                sdspi_pkg::OP_READ: begin
                    cur_block = q.block_address; appending = 1'b0;
                    begin_cmd(sdspi_pkg::PH_CMD17);
                end
                sdspi_pkg::OP_WRITE: begin
                    cur_block = q.block_address; appending = 1'b0;
                    begin_cmd(sdspi_pkg::PH_CMD24);
                end
                sdspi_pkg::OP_APPEND: begin
                    if (!card_up) close_op(sdspi_pkg::ST_NOT_READY);
                    else begin
                        cur_block = ring_ptr; appending = 1'b1;
                        begin_cmd(sdspi_pkg::PH_CMD24);
                    end
                end
                default: ;
            endcase
        end
        if (!step_out.exchange_request) begin
            step_out.tx_byte = 8'h00;
            step_out.chip_select_active = 1'b0;
            step_out.pause_ms = 1'b0;
        end
        step_out.card_ready = card_up;
        return step_out;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // card answer that mostly keeps the sequence moving forward
    function automatic logic [7:0] card_answer();
        int roll;
        roll = $urandom_range(0, 99);
        case (seq_phase)
            sdspi_pkg::PH_CMD0, sdspi_pkg::PH_CMD8, sdspi_pkg::PH_CMD55,
            sdspi_pkg::PH_CMD41, sdspi_pkg::PH_CMD58, sdspi_pkg::PH_CMD17,
            sdspi_pkg::PH_CMD24: begin
                if (byte_cnt < 7 || roll < 25) return (roll < 5) ? 8'($urandom) : 8'hFF;
                if (seq_phase == sdspi_pkg::PH_CMD0)
                    return (roll < 90) ? 8'h01 : 8'($urandom);
                if (seq_phase == sdspi_pkg::PH_CMD41) return (roll < 60) ? 8'h00 : 8'h01;
                return (roll < 88) ? 8'h00 : 8'($urandom);
            end
            sdspi_pkg::PH_TOKEN:
                return (roll < 40) ? 8'hFE : ((roll < 90) ? 8'hFF : 8'($urandom));
            sdspi_pkg::PH_WRESP:
                return (roll < 85) ? {3'($urandom), 5'h05} : 8'($urandom);
            sdspi_pkg::PH_BUSY:
                return (roll < 70) ? 8'h00 : 8'($urandom_range(1, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic sdspi_pkg::t_req random_item();
        sdspi_pkg::t_req q;
        int              roll;
        q.block_address = $urandom;
        roll = $urandom_range(0, 9);
        if (roll == 0) q.block_address = 32'hFFFF_FFFF;
        else if (roll == 1) q.block_address = 32'h0;
        q.card_byte    = card_answer();
        q.payload_byte = $urandom;
        roll = $urandom_range(0, 99);
        if (seq_phase != sdspi_pkg::PH_IDLE) begin
            q.operation = (roll < 10) ? 3'($urandom) : sdspi_pkg::OP_NONE;
        end else begin
            if (roll < 18)      q.operation = sdspi_pkg::OP_INIT;
            else if (roll < 30) q.operation = sdspi_pkg::OP_READ;
            else if (roll < 40) q.operation = sdspi_pkg::OP_WRITE;
            else if (roll < 75) q.operation = sdspi_pkg::OP_APPEND;
            else if (roll < 88) q.operation = sdspi_pkg::OP_NONE;
            else                q.operation = 3'($urandom_range(5, 7));
        end
        return q;
    endfunction

    // offer one transaction, wait for the handshake, then log its result
    task automatic offer(sdspi_pkg::t_req q, bit typed, sdspi_pkg::t_rsp want,
                         bit no_gaps);
        int              gap;
        sdspi_pkg::t_rsp got;
        gap = (!no_gaps && $urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= q;
        do @(posedge i_clk); while (!in_ch.ready);
        got = sequencer_step(q);
        pending_rsp.push_back(typed ? want : got);
    endtask

    // one random transaction; a middle stretch runs with no idling on either side
    task automatic send_random();
        steady = (sent >= 700 && sent < 1000);
        offer(random_item(), 0, '0, steady);
        sent++;
    endtask

    task automatic reg_write(sdspi_pkg::t_reg idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            sdspi_pkg::REG_RING_START:  ring_base   = val;
            sdspi_pkg::REG_RING_TOTAL:  ring_len    = val;
            sdspi_pkg::REG_RESP_TRIES:  resp_limit  = val[7:0];
            sdspi_pkg::REG_INIT_TRIES:  init_limit  = val[15:0];
            sdspi_pkg::REG_TOKEN_TRIES: token_limit = val[15:0];
            default:                    busy_limit  = val[15:0];
        endcase
    endtask

    function automatic sdspi_pkg::t_rsp typed_rsp(logic [7:0] tx, logic req, logic cs,
                                                  logic done, sdspi_pkg::t_status st);
        sdspi_pkg::t_rsp r;
        r = '0;
        r.tx_byte = tx; r.exchange_request = req; r.chip_select_active = cs;
        r.done_res = done; r.status = st;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct {
        sdspi_pkg::t_req q;
        bit              typed;
        sdspi_pkg::t_rsp want;
    } t_row;

    function automatic t_row row(logic [2:0] op, logic [31:0] blk, logic [7:0] cb,
                                 logic [7:0] pay, bit typed, sdspi_pkg::t_rsp want);
        t_row r;
        r.q.operation = op; r.q.block_address = blk;
        r.q.card_byte = cb; r.q.payload_byte = pay;
        r.typed = typed; r.want = want;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls, one long hold-off, one stall-free stretch
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_cycle = 0;
        end else begin
            rx_cycle = rx_cycle + 1;
            if (rx_cycle >= 300 && rx_cycle < 700) out_ch.ready <= 1'b0;
            else if (steady) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    function automatic void field_check(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        sdspi_pkg::t_rsp want;
        sdspi_pkg::t_rsp got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_rsp.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, expected none actual %h",
                         $time, got);
            end else begin
                want = pending_rsp.pop_front();
                field_check("tx_byte",            want.tx_byte,            got.tx_byte);
                field_check("exchange_request",   want.exchange_request,
                            got.exchange_request);
                field_check("chip_select_active", want.chip_select_active,
                            got.chip_select_active);
                field_check("pause_ms",           want.pause_ms,           got.pause_ms);
                field_check("payload_taken",      want.payload_taken,      got.payload_taken);
                field_check("read_byte",          want.read_byte,          got.read_byte);
                field_check("read_valid",         want.read_valid,         got.read_valid);
                field_check("done_res",           want.done_res,           got.done_res);
                field_check("status",             want.status,             got.status);
                field_check("card_ready",         want.card_ready,         got.card_ready);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row        rows[$];
        logic [31:0] settings[Phases][6];
        int          waited;

        errors = 0;
        sent   = 0;
        steady = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= sdspi_pkg::REG_RING_START;
        i_cfg_data  <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;

        // model reset values
        ring_base = 32'd1000; ring_len = 32'd8388608; resp_limit = 8'd8;
        init_limit = 16'd1000; token_limit = 16'd1000; busy_limit = 16'd50000;
        seq_phase = sdspi_pkg::PH_IDLE; byte_cnt = '0; try_cnt = '0; cur_block = '0;
        ring_ptr = 32'd1000; card_up = 1'b0; appending = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // append before init, idle exchanges, read rejected, start of init
        rows.push_back(row(sdspi_pkg::OP_APPEND, 32'h0, 8'h00, 8'h00, 1,
                           typed_rsp(8'h00, 0, 0, 1, sdspi_pkg::ST_NOT_READY)));
        rows.push_back(row(sdspi_pkg::OP_NONE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1,
                           typed_rsp(8'h00, 0, 0, 0, sdspi_pkg::ST_OK)));
        rows.push_back(row(OP_UNUSED, 32'h0, 8'h00, 8'h00, 1,
                           typed_rsp(8'h00, 0, 0, 0, sdspi_pkg::ST_OK)));
        rows.push_back(row(sdspi_pkg::OP_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1,
                           typed_rsp(8'h51, 1, 1, 0, sdspi_pkg::ST_OK)));
        for (int k = 0; k < 6; k++)
            rows.push_back(row(sdspi_pkg::OP_NONE, 32'h0, 8'hFF, 8'h00, 0, '0));
        // a start while busy is taken as the card's response byte
        rows.push_back(row(sdspi_pkg::OP_WRITE, 32'h0, 8'h04, 8'h00, 1,
                           typed_rsp(8'h00, 0, 0, 1, sdspi_pkg::ST_CMD_REJECTED)));
        rows.push_back(row(sdspi_pkg::OP_INIT, 32'h0, 8'h00, 8'h00, 1,
                           typed_rsp(8'hFF, 1, 0, 0, sdspi_pkg::ST_OK)));
        for (int k = 0; k < 10; k++)
            rows.push_back(row(sdspi_pkg::OP_NONE, 32'h0, 8'hFF, 8'h00, 0, '0));

        foreach (rows[k]) offer(rows[k].q, rows[k].typed, rows[k].want, 1'b0);

        // register settings per phase: start, total, response, init, token, busy
        settings[0] = '{32'd1000, 32'd8388608, 32'd8, 32'd1000, 32'd1000, 32'd50000};
        settings[1] = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0};
        settings[2] = '{32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd255, 32'd65535, 32'd65535,
                        32'd65535};
        settings[3] = '{$urandom, 32'($urandom_range(1, 4)), 32'($urandom_range(1, 4)),
                        32'($urandom_range(1, 3)), 32'($urandom_range(1, 5)),
                        32'($urandom_range(1, 5))};
        settings[4] = '{32'd5, 32'd3, 32'd2, 32'd2, 32'd3, 32'd2};

        for (int p = 0; p < Phases; p++) begin
            // finish the operation in flight, then drain before touching registers
            while (seq_phase != sdspi_pkg::PH_IDLE) send_random();
            in_ch.valid <= 1'b0;
            waited = 0;
            while (pending_rsp.size() != 0 && waited < 100000) begin
                @(posedge i_clk);
                waited++;
            end
            repeat (4) @(posedge i_clk);
            for (int r = 0; r < 6; r++) reg_write(sdspi_pkg::t_reg'(r), settings[p][r]);
            i_cfg_we <= 1'b0;

            // transactions that finish an operation count toward the budget
            while (sent < (p + 1) * (RandomItems / Phases)) send_random();
        end
        while (seq_phase != sdspi_pkg::PH_IDLE) send_random();
        steady = 1'b0;
        in_ch.valid <= 1'b0;

        waited = 0;
        while (pending_rsp.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);

        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (pending_rsp.size() != 0)
                $display("%0t: %0d results expected but never seen, actual none",
                         $time, pending_rsp.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
